[design/two_level_feedback_queue_scheduler_macros.svh]
// Assertion macros for the scheduler checker.
`ifndef TWO_LEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH
`define TWO_LEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TLFQS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TLFQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tlfqs_pkg.sv]
// Types and constants of the two-level feedback queue scheduler.
`timescale 1ns / 1ps

package tlfqs_pkg;

  localparam int MAX_TASKS_DEF   = 65536;
  localparam int QUEUE_DEPTH_DEF = 256;

  localparam int SLICE_W = 10;
  localparam int CPU_W   = 8;
  localparam int TASK_W  = 16;
  localparam int CFG_AW  = 1;

  localparam logic [SLICE_W-1:0] HIGH_SLICE_RST = SLICE_W'(50);
  localparam logic [CPU_W-1:0]   WATCH_CPU_RST  = '0;

  localparam logic [CFG_AW-1:0] REG_HIGH_SLICE = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_WATCH_CPU  = CFG_AW'(1);

  typedef enum logic [2:0] {
    OP_ENABLE   = 3'd0,
    OP_DISABLE  = 3'd1,
    OP_ENQUEUE  = 3'd2,
    OP_DISPATCH = 3'd3,
    OP_STOPPING = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_DEMOTED  = 2'd1,
    EV_LEFT_LOW = 2'd2
  } event_code_t;

  // Declared from the highest bit down; opcode sits in the lowest bits.
  typedef struct packed {
    logic [2:0]        pad;
    logic              slice_used_up;
    logic              still_runnable;
    logic [CPU_W-1:0]  cpu;
    logic [TASK_W-1:0] task_id;
    opcode_t           opcode;
  } in_item_t;

  // Declared from the highest bit down; task_out sits in the lowest bits.
  typedef struct packed {
    logic               queue_full;
    event_code_t        event_code;
    logic               slice_unlimited;
    logic [SLICE_W-1:0] slice_ms;
    logic               queue_used;
    logic               task_valid;
    logic [TASK_W-1:0]  task_out;
  } out_item_t;

endpackage

[design/two_level_feedback_queue_scheduler.sv]
// Two-level feedback queue scheduler with a level memory and a shared queue memory.
// An accepted item and its level and queue memory reads are registered; its result enters the
// output register, and the level and queue writes are made, once the execute state finds the
// output free, so a stalled output holds the write-back. No new item is taken meanwhile.
// Reset: synchronous; afterwards a clearing pass writes MAX_TASKS/8 level rows with s_tready
// low; configuration writes are taken meanwhile.
`timescale 1ns / 1ps

module two_level_feedback_queue_scheduler #(
  parameter int MAX_TASKS   = tlfqs_pkg::MAX_TASKS_DEF,
  parameter int QUEUE_DEPTH = tlfqs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // opcode, task_id, cpu, still_runnable, slice_used_up, zero pad
  input  logic [31:0]                   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // task_out, task_valid, queue_used, slice_ms, slice_unlimited, event_code, queue_full
  output logic [31:0]                   m_tdata,
  input  logic                          cfg_we,
  input  logic [tlfqs_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [tlfqs_pkg::SLICE_W-1:0] cfg_wdata
);

  localparam int TASK_AW    = $clog2(MAX_TASKS);
  localparam int LVL_ROW_W  = 8;
  localparam int LVL_BIT_AW = $clog2(LVL_ROW_W);
  localparam int LVL_ROWS   = MAX_TASKS / LVL_ROW_W;
  localparam int ROW_AW     = TASK_AW - LVL_BIT_AW;
  localparam int QAW        = $clog2(QUEUE_DEPTH);
  localparam int QCW        = QAW + 1;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t                         state, state_next;
  logic [ROW_AW-1:0]              clr_row;
  logic [tlfqs_pkg::SLICE_W-1:0]  high_slice_ms;
  logic [tlfqs_pkg::CPU_W-1:0]    watch_cpu;
  tlfqs_pkg::in_item_t            in_item, item;
  tlfqs_pkg::out_item_t           res, out_item;

  logic [LVL_ROW_W-1:0]           lvl_mem [LVL_ROWS];
  logic [LVL_ROW_W-1:0]           lvl_rdata, row_mod;
  logic [tlfqs_pkg::TASK_W-1:0]   q_mem [2**QCW];
  logic [tlfqs_pkg::TASK_W-1:0]   q_rdata;
  logic [QCW-1:0]                 q_waddr, q_raddr;
  logic [QAW-1:0]                 high_head, low_head;
  logic [QCW-1:0]                 high_count, low_count;

  logic                           accept, exec_go, traced, lvl_bit, new_bit, lvl_op;
  logic                           lvl_we;
  logic [ROW_AW-1:0]              lvl_waddr;
  logic [LVL_ROW_W-1:0]           lvl_wdata;
  logic [TASK_AW-1:0]             in_slot, item_slot;
  logic [ROW_AW-1:0]              item_row;
  logic [LVL_BIT_AW-1:0]          item_bit;
  logic                           hq_push, lq_push, hq_pop, lq_pop;
  logic [QCW-1:0]                 hq_sum, lq_sum;
  logic [QAW-1:0]                 hq_tail, lq_tail;

  assign in_item   = tlfqs_pkg::in_item_t'(s_tdata);
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign exec_go   = (state == ST_EXEC) && (!m_tvalid || m_tready);
  assign m_tdata   = out_item;

  assign in_slot   = TASK_AW'(in_item.task_id);
  assign item_slot = TASK_AW'(item.task_id);
  assign item_row  = item_slot[TASK_AW-1:LVL_BIT_AW];
  assign item_bit  = item_slot[LVL_BIT_AW-1:0];
  assign lvl_bit   = lvl_rdata[item_bit];
  assign traced    = (item.cpu == watch_cpu);

  // Tail slot of each queue: head plus count, wrapped once.
  assign hq_sum  = QCW'(high_head) + high_count;
  assign lq_sum  = QCW'(low_head) + low_count;
  assign hq_tail = (hq_sum >= QCW'(QUEUE_DEPTH)) ? QAW'(hq_sum - QCW'(QUEUE_DEPTH))
                                                 : QAW'(hq_sum);
  assign lq_tail = (lq_sum >= QCW'(QUEUE_DEPTH)) ? QAW'(lq_sum - QCW'(QUEUE_DEPTH))
                                                 : QAW'(lq_sum);

  // The high queue lives in the lower half of the queue memory, the low queue in the upper.
  assign q_waddr = lq_push ? {1'b1, lq_tail} : {1'b0, hq_tail};
  assign q_raddr = (high_count != '0) ? {1'b0, high_head} : {1'b1, low_head};

  always_comb begin
    res              = '0;
    res.task_out     = item.task_id;
    res.event_code   = tlfqs_pkg::EV_NONE;
    new_bit          = lvl_bit;
    lvl_op           = 1'b0;
    hq_push          = 1'b0;
    lq_push          = 1'b0;
    hq_pop           = 1'b0;
    lq_pop           = 1'b0;
    case (item.opcode)
      tlfqs_pkg::OP_ENABLE: begin
        new_bit = 1'b0;
        lvl_op  = 1'b1;
      end
      tlfqs_pkg::OP_DISABLE: begin
        if (lvl_bit && traced) begin
          res.event_code = tlfqs_pkg::EV_LEFT_LOW;
        end
        new_bit = 1'b0;
        lvl_op  = 1'b1;
      end
      tlfqs_pkg::OP_ENQUEUE: begin
        if (!lvl_bit) begin
          res.slice_ms = high_slice_ms;
          if (high_count == QCW'(QUEUE_DEPTH)) begin
            res.queue_full = 1'b1;
          end else begin
            hq_push = 1'b1;
          end
        end else begin
          res.queue_used      = 1'b1;
          res.slice_unlimited = 1'b1;
          if (low_count == QCW'(QUEUE_DEPTH)) begin
            res.queue_full = 1'b1;
          end else begin
            lq_push = 1'b1;
          end
        end
      end
      tlfqs_pkg::OP_DISPATCH: begin
        res.task_out = '0;
        if (high_count != '0) begin
          res.task_out   = q_rdata;
          res.task_valid = 1'b1;
          hq_pop         = 1'b1;
        end else if (low_count != '0) begin
          res.task_out   = q_rdata;
          res.task_valid = 1'b1;
          res.queue_used = 1'b1;
          lq_pop         = 1'b1;
        end
      end
      tlfqs_pkg::OP_STOPPING: begin
        if (item.still_runnable && !lvl_bit && item.slice_used_up) begin
          new_bit = 1'b1;
          lvl_op  = 1'b1;
          if (traced) begin
            res.event_code = tlfqs_pkg::EV_DEMOTED;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    row_mod           = lvl_rdata;
    row_mod[item_bit] = new_bit;
  end

  assign lvl_we    = (state == ST_CLEAR) || (exec_go && lvl_op);
  assign lvl_waddr = (state == ST_CLEAR) ? clr_row : item_row;
  assign lvl_wdata = (state == ST_CLEAR) ? '0 : row_mod;

  always_ff @(posedge clk) begin
    if (lvl_we) begin
      lvl_mem[lvl_waddr] <= lvl_wdata;
    end
    if (accept) begin
      lvl_rdata <= lvl_mem[in_slot[TASK_AW-1:LVL_BIT_AW]];
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go && (hq_push || lq_push)) begin
      q_mem[q_waddr] <= item.task_id;
    end
    if (accept) begin
      q_rdata <= q_mem[q_raddr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_row == ROW_AW'(LVL_ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_row       <= '0;
      high_head     <= '0;
      high_count    <= '0;
      low_head      <= '0;
      low_count     <= '0;
      m_tvalid      <= 1'b0;
      high_slice_ms <= tlfqs_pkg::HIGH_SLICE_RST;
      watch_cpu     <= tlfqs_pkg::WATCH_CPU_RST;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_row <= clr_row + 1'b1;
      end
      if (cfg_we) begin
        case (cfg_addr)
          tlfqs_pkg::REG_HIGH_SLICE: high_slice_ms <= cfg_wdata;
          tlfqs_pkg::REG_WATCH_CPU:  watch_cpu <= cfg_wdata[tlfqs_pkg::CPU_W-1:0];
          default: begin
          end
        endcase
      end
      if (exec_go) begin
        if (hq_push) begin
          high_count <= high_count + 1'b1;
        end
        if (lq_push) begin
          low_count <= low_count + 1'b1;
        end
        if (hq_pop) begin
          high_count <= high_count - 1'b1;
          high_head  <= (high_head == QAW'(QUEUE_DEPTH - 1)) ? '0 : high_head + 1'b1;
        end
        if (lq_pop) begin
          low_count <= low_count - 1'b1;
          low_head  <= (low_head == QAW'(QUEUE_DEPTH - 1)) ? '0 : low_head + 1'b1;
        end
      end
      if (exec_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
    if (exec_go) begin
      out_item <= res;
    end
  end

endmodule

[design/tlfqs_checker.sv]
// Port-level checker for the scheduler, bound to the top level.
`timescale 1ns / 1ps
`include "two_level_feedback_queue_scheduler_macros.svh"

module tlfqs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  tlfqs_pkg::out_item_t res;

  assign res = tlfqs_pkg::out_item_t'(m_tdata);

  `TLFQS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
  `TLFQS_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready, "item accepted while another is in flight")
  `TLFQS_ASSERT_SAME(a_after_reset, clk, rst, $past(rst), !s_tready && !m_tvalid, "not quiet after reset")
  `TLFQS_ASSERT_SAME(a_low_slice, clk, rst, m_tvalid && res.slice_unlimited, res.queue_used && (res.slice_ms == '0), "unlimited slice on wrong queue")
  `TLFQS_ASSERT_SAME(a_event_code, clk, rst, m_tvalid, res.event_code != 2'b11, "undefined event code")

endmodule

bind two_level_feedback_queue_scheduler tlfqs_checker u_checker (.*);
